// ===== sv/rrw_pkg.sv =====
// shared types and constants for the receiver reorder window
package rrw_pkg;

  // fixed field widths
  localparam int SEQ_BITS     = 4;
  localparam int PAYLOAD_MAX  = 64;
  localparam int TDATA_BITS   = 72;

  // parameter defaults
  localparam int WINDOW_DEF       = 8;
  localparam int SEQ_SPACE_DEF    = 16;
  localparam int PAYLOAD_BITS_DEF = 64;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN
  } state_t;

  // control strobes from sequencer to slot store
  typedef struct packed {
    logic wr_en;
    logic take_en;
  } store_ctrl_t;

endpackage

// ===== sv/rrw_slot_calc.sv =====
// maps a sequence number to its window slot and physical buffer index
module rrw_slot_calc #(
  parameter int WINDOW    = rrw_pkg::WINDOW_DEF,
  parameter int SEQ_SPACE = rrw_pkg::SEQ_SPACE_DEF,
  localparam int BW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1,
  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic [rrw_pkg::SEQ_BITS-1:0] seq,
  input  logic [BW-1:0]                base,
  input  logic [IW-1:0]                head,
  output logic                         in_win,
  output logic                         slot_zero,
  output logic [IW-1:0]                phys
);

  localparam int PW = IW + 1;
  localparam int CW = (BW + 1 > 8) ? BW + 1 : 8;

  logic [8:0]    seq_red;
  logic [BW:0]   diff;
  logic [PW-1:0] psum;

  // reduce seq modulo the sequence space, at most eight subtract steps
  always_comb begin
    seq_red = {5'b0, seq};
    for (int i = 0; i < 8; i++) begin
      if (seq_red >= 9'(SEQ_SPACE)) begin
        seq_red = seq_red - 9'(SEQ_SPACE);
      end
    end
  end

  // slot offset from the base, one conditional subtract
  always_comb begin
    diff = (BW + 1)'(seq_red) + (BW + 1)'(SEQ_SPACE) - {1'b0, base};
    if (diff >= (BW + 1)'(SEQ_SPACE)) begin
      diff = diff - (BW + 1)'(SEQ_SPACE);
    end
  end

  assign in_win    = CW'(diff) < CW'(WINDOW);
  assign slot_zero = (diff == '0);

  // circular buffer index
  always_comb begin
    psum = PW'(head) + PW'(diff);
    if (psum >= PW'(WINDOW)) begin
      psum = psum - PW'(WINDOW);
    end
  end

  assign phys = psum[IW-1:0];

endmodule

// ===== sv/rrw_slot_store.sv =====
// circular payload buffer with per-slot present flags
module rrw_slot_store #(
  parameter int WINDOW       = rrw_pkg::WINDOW_DEF,
  parameter int PAYLOAD_BITS = rrw_pkg::PAYLOAD_BITS_DEF,
  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rrw_pkg::store_ctrl_t     ctrl,
  input  logic [IW-1:0]            wr_idx,
  input  logic [PAYLOAD_BITS-1:0]  wr_data,
  input  logic [IW-1:0]            rd_idx,
  input  logic [IW-1:0]            nxt_idx,
  output logic                     wr_present,
  output logic                     head_present,
  output logic                     next_present,
  output logic [PAYLOAD_BITS-1:0]  rd_data
);

  logic [PAYLOAD_BITS-1:0] mem [WINDOW];
  logic [WINDOW-1:0]       present;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (ctrl.take_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else begin
      if (ctrl.wr_en) begin
        present[wr_idx] <= 1'b1;
      end
      if (ctrl.take_en) begin
        present[rd_idx] <= 1'b0;
      end
    end
  end

  assign wr_present   = present[wr_idx];
  assign head_present = present[rd_idx];
  // the slot being taken does not count as its own successor
  assign next_present = present[nxt_idx] && (nxt_idx != rd_idx);

endmodule

// ===== sv/receiver_reorder_window_core.sv =====
// top level of the selective-repeat receiver reorder window
//
// s_* channel: one received frame per word, tdata holds seq and payload.
// m_* channel: frames released in sequence order, tlast marks the final
// word released by one received frame.
// a received frame whose slot lies outside the window or is already
// filled is dropped and releases nothing.
// timing: a frame is taken in idle, its slot is checked and written in
// the next cycle. a frame that fills the window base then releases its
// run of n words, one per cycle while m_tready is high; the drain loop
// reads one buffer entry per cycle through the single memory read port
// and waits whenever the receiver stalls.
// s_tready is high only in idle; the final word of a run may still sit
// in the output register while the next frame is taken.
// reset: window base and buffer head go to zero and all present flags
// clear at once; no sweep is needed.
module receiver_reorder_window_core #(
  parameter int WINDOW       = rrw_pkg::WINDOW_DEF,
  parameter int SEQ_SPACE    = rrw_pkg::SEQ_SPACE_DEF,
  parameter int PAYLOAD_BITS = rrw_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // seq [3:0], payload [67:4], zero fill [71:68]
  input  logic [rrw_pkg::TDATA_BITS-1:0] s_tdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // out_seq [3:0], out_payload [67:4], zero fill [71:68]
  output logic [rrw_pkg::TDATA_BITS-1:0] m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic                           m_tlast
);

  localparam int BW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SB = rrw_pkg::SEQ_BITS;

  rrw_pkg::state_t      state, state_next;
  rrw_pkg::store_ctrl_t ctrl;

  logic [BW-1:0]           base;
  logic [BW-1:0]           base_inc;
  logic [IW-1:0]           head;
  logic [IW-1:0]           head_inc;
  logic [SB-1:0]           seq_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic                    out_valid;
  logic [SB-1:0]           out_seq;
  logic                    out_last;
  logic [PAYLOAD_BITS-1:0] rd_data;

  logic          in_win;
  logic          slot_zero;
  logic [IW-1:0] phys;
  logic          wr_present;
  logic          head_present;
  logic          next_present;
  logic          out_free;

  // slot mapping of the held frame
  rrw_slot_calc #(
    .WINDOW    (WINDOW),
    .SEQ_SPACE (SEQ_SPACE)
  ) u_calc (
    .seq       (seq_r),
    .base      (base),
    .head      (head),
    .in_win    (in_win),
    .slot_zero (slot_zero),
    .phys      (phys)
  );

  // buffer and present flags
  rrw_slot_store #(
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .wr_idx       (phys),
    .wr_data      (pay_r),
    .rd_idx       (head),
    .nxt_idx      (head_inc),
    .wr_present   (wr_present),
    .head_present (head_present),
    .next_present (next_present),
    .rd_data      (rd_data)
  );

  // wrap-around increments of base sequence and buffer head
  assign base_inc = (base == BW'(SEQ_SPACE - 1)) ? '0 : base + 1'b1;
  assign head_inc = (head == IW'(WINDOW - 1)) ? '0 : head + 1'b1;

  // output register can take a new word
  assign out_free = !out_valid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rrw_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = rrw_pkg::ST_CALC;
        end
      end
      rrw_pkg::ST_CALC: begin
        // only a frame landing on the base opens a run
        if (in_win && !wr_present && slot_zero) begin
          state_next = rrw_pkg::ST_DRAIN;
        end else begin
          state_next = rrw_pkg::ST_IDLE;
        end
      end
      rrw_pkg::ST_DRAIN: begin
        if (out_free && !next_present) begin
          state_next = rrw_pkg::ST_IDLE;
        end
      end
      default: state_next = rrw_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready     = 1'b0;
    ctrl.wr_en   = 1'b0;
    ctrl.take_en = 1'b0;
    case (state)
      rrw_pkg::ST_IDLE:  s_tready = 1'b1;
      rrw_pkg::ST_CALC:  ctrl.wr_en = in_win && !wr_present;
      rrw_pkg::ST_DRAIN: ctrl.take_en = out_free;
      default: begin
        s_tready     = 1'b0;
        ctrl.wr_en   = 1'b0;
        ctrl.take_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the accepted frame
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      seq_r <= s_tdata[SB-1:0];
      pay_r <= s_tdata[SB +: PAYLOAD_BITS];
    end
  end

  // window base and buffer head move one slot per released word
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      head <= '0;
    end else if (ctrl.take_en) begin
      base <= base_inc;
      head <= head_inc;
    end
  end

  // output word register, payload comes from the buffer read register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.take_en) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take_en) begin
      out_seq  <= SB'(base);
      out_last <= !next_present;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {4'b0, rrw_pkg::PAYLOAD_MAX'(rd_data), out_seq};

`ifndef SYNTH
  // an accepted frame is always checked in the next cycle
  a_accept_calc: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == rrw_pkg::ST_CALC))
    else $error("accepted frame not followed by slot check");

  // the base slot is empty whenever the block waits for a frame
  a_idle_base_empty: assert property (@(posedge clk) disable iff (rst)
    (state == rrw_pkg::ST_IDLE) |-> !head_present)
    else $error("base slot filled while idle");

  // every drain cycle finds a frame at the base slot
  a_drain_base_full: assert property (@(posedge clk) disable iff (rst)
    (state == rrw_pkg::ST_DRAIN) |-> head_present)
    else $error("drain reached an empty slot");

  // a released word shows up on the output
  a_take_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.take_en |=> m_tvalid)
    else $error("released word not presented");
`endif

endmodule

// ===== dv/rrw_delivery_monitor.sv =====
// watcher that predicts in-order frame release and checks the output stream
module rrw_delivery_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rrw_pkg::TDATA_BITS-1:0] s_tdata,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [rrw_pkg::TDATA_BITS-1:0] m_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           m_tlast,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN   = rrw_pkg::WINDOW_DEF;
  localparam int SPACE = rrw_pkg::SEQ_SPACE_DEF;
  localparam int SB    = rrw_pkg::SEQ_BITS;
  localparam int PB    = rrw_pkg::PAYLOAD_MAX;

  typedef struct {
    logic [SB-1:0] seq;
    logic [PB-1:0] payload;
    logic          last;
  } release_word_t;

  release_word_t release_q[$];
  int unsigned   base_seq;
  logic          held[WIN];
  logic [PB-1:0] held_payload[WIN];
  int            mismatches;

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
  end

  // store the frame if it lands on a free slot, then release the run from slot 0
  task automatic predict_release(input logic [SB-1:0] sq, input logic [PB-1:0] pl);
    int unsigned   slot;
    int unsigned   run;
    release_word_t w;
    slot = (int'(sq) % SPACE + SPACE - base_seq) % SPACE;
    if (slot >= WIN || held[slot]) return;
    held[slot]         = 1'b1;
    held_payload[slot] = pl;
    run = 0;
    while (run < WIN && held[run]) begin
      w.seq     = SB'((base_seq + run) % SPACE);
      w.payload = held_payload[run];
      w.last    = 1'b0;
      release_q.push_back(w);
      run++;
    end
    if (run == 0) return;
    release_q[$].last = 1'b1;
    base_seq = (base_seq + run) % SPACE;
    for (int i = 0; i < WIN; i++) begin
      if (i + run < WIN) begin
        held[i]         = held[i + run];
        held_payload[i] = held_payload[i + run];
      end else begin
        held[i] = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    release_word_t got_w;
    release_word_t exp_w;
    if (rst) begin
      base_seq = 0;
      for (int i = 0; i < WIN; i++) held[i] = 1'b0;
      release_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got_w.seq     = m_tdata[SB-1:0];
        got_w.payload = m_tdata[SB +: PB];
        got_w.last    = m_tlast;
        if (release_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word seq=%h payload=%h last=%b", $realtime,
                     got_w.seq, got_w.payload, got_w.last);
        end else begin
          exp_w = release_q.pop_front();
          if (got_w.seq !== exp_w.seq || got_w.payload !== exp_w.payload ||
              got_w.last !== exp_w.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: wrong word exp seq=%h payload=%h last=%b, got seq=%h payload=%h last=%b",
                       $realtime, exp_w.seq, exp_w.payload, exp_w.last,
                       got_w.seq, got_w.payload, got_w.last);
          end
        end
      end
      if (s_tvalid && s_tready)
        predict_release(s_tdata[SB-1:0], s_tdata[SB +: PB]);
    end
    fail_count <= mismatches;
    pending    <= release_q.size();
  end

endmodule

// ===== dv/tb_receiver_reorder_window_core.sv =====
// testbench top: frame stimulus, receiver stalls and final verdict
module tb_receiver_reorder_window_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          GOOD_TOTAL = 390;     // in-window frames in the random part
  localparam int          QUIET_FROM = 330;     // no idling on either side after this
  localparam int unsigned LIMIT      = 500000;  // cycles before the run is declared hung

  typedef enum logic [1:0] {
    NOISE_AHEAD,   // beyond the window's far edge
    NOISE_BEHIND,  // already released, behind the base
    NOISE_REPEAT   // copy of a frame still held in the window
  } noise_kind_e;

  logic                           clk = 1'b0;
  logic                           rst;
  logic [rrw_pkg::TDATA_BITS-1:0] s_tdata;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [rrw_pkg::TDATA_BITS-1:0] m_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic                           m_tlast;
  int                             fail_count;
  int                             pending;
  logic                           tail_quiet = 1'b0;
  int unsigned                    cycle_count = 0;

  always #5 clk = ~clk;

  receiver_reorder_window_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
  );

  rrw_delivery_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // payloads lean on the extremes now and then
  function automatic logic [63:0] frame_payload();
    case ($urandom_range(0, 9))
      0:       return 64'h0;
      1:       return '1;
      2:       return 64'h5555_5555_5555_5555;
      3:       return 64'haaaa_aaaa_aaaa_aaaa;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one frame, maybe after an idle burst, and hold it until taken
  task automatic send_frame(input logic [3:0] sq, input logic [63:0] pl);
    if (!tail_quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tdata  <= {4'b0000, pl, sq};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // receiver: ready stretches broken by stall bursts, steady ready in the tail
  initial begin
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      if (tail_quiet) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 30)) @(posedge clk);
        if (!tail_quiet) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int          good_sent;
    int          k;
    int          j;
    int          pos;
    logic [3:0]  stim_base;
    logic [3:0]  tmp;
    logic [3:0]  order[8];
    logic        base_taken;
    noise_kind_e kind;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: single release, gap then fill, duplicate, out of window,
    // stale frame, full window drain, and a run that wraps the sequence space
    send_frame(4'd0,  '1);
    send_frame(4'd2,  64'h0);
    send_frame(4'd2,  64'h5555_5555_5555_5555);  // duplicate keeps the first
    send_frame(4'd1,  64'haaaa_aaaa_aaaa_aaaa);
    send_frame(4'd11, 64'h0123_4567_89ab_cdef);  // one past the window
    send_frame(4'd2,  64'hfedc_ba98_7654_3210);  // already released
    for (int s = 10; s >= 4; s--) send_frame(4'(s), frame_payload());
    send_frame(4'd3,  frame_payload());          // releases all eight slots
    send_frame(4'd12, frame_payload());
    send_frame(4'd11, frame_payload());
    send_frame(4'd15, frame_payload());
    send_frame(4'd0,  frame_payload());
    send_frame(4'd14, frame_payload());
    send_frame(4'd13, frame_payload());          // run 13, 14, 15, 0
    stim_base = 4'd1;

    // random: blocks of consecutive sequence numbers in shuffled order; while
    // the block's first frame is held back the base stays put, so noise frames
    // can be aimed at known outcomes
    good_sent = 0;
    while (good_sent < GOOD_TOTAL) begin
      k = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(1, 8);
      for (int i = 0; i < k; i++) order[i] = stim_base + 4'(i);
      for (int i = k - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      if ($urandom_range(0, 1) == 0) begin
        for (int i = 0; i < k; i++) if (order[i] == stim_base) pos = i;
        tmp          = order[k - 1];
        order[k - 1] = order[pos];
        order[pos]   = tmp;
      end
      base_taken = 1'b0;
      for (int i = 0; i < k; i++) begin
        if (!base_taken && $urandom_range(0, 4) == 0) begin
          kind = noise_kind_e'($urandom_range(0, 2));
          case (kind)
            NOISE_AHEAD:  send_frame(stim_base + 4'd8 + 4'($urandom_range(0, 7)),
                                     frame_payload());
            NOISE_BEHIND: send_frame(stim_base - 4'd1 - 4'($urandom_range(0, 7)),
                                     frame_payload());
            default: begin
              if (i > 0) send_frame(order[$urandom_range(0, i - 1)], frame_payload());
            end
          endcase
        end
        if (order[i] == stim_base) base_taken = 1'b1;
        send_frame(order[i], frame_payload());
        good_sent++;
        if (good_sent >= QUIET_FROM) tail_quiet = 1'b1;
      end
      stim_base = stim_base + 4'(k);
    end
    s_tvalid <= 1'b0;

    // drain: the monitor's pending count is registered, so wait for it to update before looking
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rrw_pkg.sv
sv/rrw_slot_calc.sv
sv/rrw_slot_store.sv
sv/receiver_reorder_window_core.sv
dv/rrw_delivery_monitor.sv
dv/tb_receiver_reorder_window_core.sv
